// ===== src/csv_record_tokenizer_assert.svh =====
// assertion helpers, clocked on aclk and held off during reset
`ifndef CSV_RECORD_TOKENIZER_ASSERT_SVH
`define CSV_RECORD_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define CSVT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csvt_pkg.sv =====
`default_nettype none

package csvt_pkg;

    localparam int MAX_FIELDS = 255;
    localparam logic [7:0] FIELD_LIMIT = 8'((MAX_FIELDS < 255) ? MAX_FIELDS : 255);

    localparam logic [7:0] LF_BYTE = 8'h0a;
    localparam logic [7:0] CR_BYTE = 8'h0d;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE     = CFG_INDEX_W'(1);

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        K_BYTE = 3'd0,
        K_FEND = 3'd1,
        K_RECF = 3'd2,
        K_RECE = 3'd3,
        K_SEND = 3'd4,
        K_ERR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_QUOTE       = 3'd1,
        ERR_AFTER_QUOTE = 3'd2,
        ERR_AFTER_CR    = 3'd3,
        ERR_COUNT       = 3'd4,
        ERR_EARLY_END   = 3'd5,
        ERR_TOO_MANY    = 3'd6
    } error_t;

    typedef enum logic [5:0] {
        ST_START = 6'b000001,
        ST_UNQ   = 6'b000010,
        ST_QUO   = 6'b000100,
        ST_AFTQ  = 6'b001000,
        ST_CRF   = 6'b010000,
        ST_CRE   = 6'b100000
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] content_byte;
        logic [7:0] fields_in_record;
        error_t     error_code;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } queue_entry_t;

endpackage

`default_nettype wire

// ===== src/csvt_front.sv =====
`default_nettype none

module csvt_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_cmd,
    input  wire logic [7:0]                        s_data_byte,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                        cfg_data,
    input  wire logic                              q_full,
    output logic                                   push,
    output csvt_pkg::queue_entry_t                 push_entry
);
    import csvt_pkg::*;

    typedef struct packed {
        state_t     st;
        logic [7:0] cnt;
        logic [7:0] exp_cnt;
        logic       known;
        logic       emit;
        logic       err;
        result_t    res;
    } feed_t;

    function automatic result_t make_result(kind_t k, logic [7:0] b, logic [7:0] n,
                                            error_t e);
        result_t r;
        r.kind             = k;
        r.content_byte     = b;
        r.fields_in_record = n;
        r.error_code       = e;
        return r;
    endfunction

    function automatic feed_t feed(state_t st, logic [7:0] cnt, logic [7:0] c,
                                   logic [7:0] sep, logic [7:0] quo,
                                   logic [7:0] exp_cnt, logic known);
        feed_t      f;
        logic       do_byte;
        logic       do_close;
        logic       do_end;
        logic       closing;
        logic       do_err;
        error_t     code;
        logic [7:0] n;
        f.st      = st;
        f.cnt     = cnt;
        f.exp_cnt = exp_cnt;
        f.known   = known;
        f.emit    = 1'b0;
        f.err     = 1'b0;
        f.res     = make_result(K_BYTE, 8'd0, 8'd0, ERR_NONE);
        do_byte   = 1'b0;
        do_close  = 1'b0;
        do_end    = 1'b0;
        closing   = 1'b0;
        do_err    = 1'b0;
        code      = ERR_NONE;
        n         = 8'd0;
        case (st)
            ST_UNQ: begin
                if (c == LF_BYTE) begin
                    do_end  = 1'b1;
                    closing = 1'b1;
                end else if (c == CR_BYTE) begin
                    f.st = ST_CRF;
                end else if (c == sep) begin
                    do_close = 1'b1;
                end else if (c == quo) begin
                    do_err = 1'b1;
                    code   = ERR_QUOTE;
                end else begin
                    do_byte = 1'b1;
                end
            end
            ST_QUO: begin
                if (c == quo) begin
                    f.st = ST_AFTQ;
                end else begin
                    do_byte = 1'b1;
                end
            end
            ST_AFTQ: begin
                if (c == LF_BYTE) begin
                    do_end  = 1'b1;
                    closing = 1'b1;
                end else if (c == CR_BYTE) begin
                    f.st = ST_CRF;
                end else if (c == sep) begin
                    do_close = 1'b1;
                end else if (c == quo) begin
                    do_byte = 1'b1;
                    f.st    = ST_QUO;
                end else begin
                    do_err = 1'b1;
                    code   = ERR_AFTER_QUOTE;
                end
            end
            ST_CRF: begin
                if (c == LF_BYTE) begin
                    do_end  = 1'b1;
                    closing = 1'b1;
                end else begin
                    do_err = 1'b1;
                    code   = ERR_AFTER_CR;
                end
            end
            ST_CRE: begin
                if (c == LF_BYTE) begin
                    do_end = 1'b1;
                end else begin
                    do_err = 1'b1;
                    code   = ERR_AFTER_CR;
                end
            end
            default: begin
                f.st = ST_START;
                if (c == LF_BYTE) begin
                    do_end = 1'b1;
                end else if (c == CR_BYTE) begin
                    f.st = ST_CRE;
                end else if (c == sep) begin
                    do_close = 1'b1;
                end else if (c == quo) begin
                    f.st = ST_QUO;
                end else begin
                    do_byte = 1'b1;
                    f.st    = ST_UNQ;
                end
            end
        endcase

        if (do_byte) begin
            f.emit = 1'b1;
            f.res  = make_result(K_BYTE, c, 8'd0, ERR_NONE);
        end

        if (do_close) begin
            if (cnt >= FIELD_LIMIT) begin
                do_err = 1'b1;
                code   = ERR_TOO_MANY;
            end else begin
                f.cnt  = cnt + 8'd1;
                f.emit = 1'b1;
                f.res  = make_result(K_FEND, 8'd0, cnt + 8'd1, ERR_NONE);
                f.st   = ST_START;
            end
        end

        if (do_end) begin
            if (closing && (cnt >= FIELD_LIMIT)) begin
                do_err = 1'b1;
                code   = ERR_TOO_MANY;
            end else begin
                n = cnt + {7'd0, closing};
                if (known && (n != exp_cnt)) begin
                    f.cnt  = n;
                    do_err = 1'b1;
                    code   = ERR_COUNT;
                end else begin
                    f.emit = 1'b1;
                    f.res  = make_result(closing ? K_RECF : K_RECE, 8'd0, n, ERR_NONE);
                    if (!known) begin
                        f.exp_cnt = n;
                        f.known   = 1'b1;
                    end
                    f.cnt = 8'd0;
                    f.st  = ST_START;
                end
            end
        end

        if (do_err) begin
            f.err  = 1'b1;
            f.emit = 1'b1;
            f.res  = make_result(K_ERR, 8'd0, 8'd0, code);
        end
        return f;
    endfunction

    state_t     st_reg,         st_next;
    logic [7:0] cnt_reg,        cnt_next;
    logic [7:0] exp_reg,        exp_next;
    logic       known_reg,      known_next;
    logic       prev_lf_reg,    prev_lf_next;
    logic       err_latched_reg, err_latched_next;
    error_t     err_code_reg,   err_code_next;
    logic [7:0] sep_reg;
    logic [7:0] quo_reg;

    logic       accept;
    logic [7:0] feed_byte;
    feed_t      f;
    logic       fed;
    logic       after_err;
    state_t     after_st;
    result_t    final_res;
    result_t    none_res;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign feed_byte = (s_cmd == CMD_END) ? LF_BYTE : s_data_byte;
    assign none_res  = make_result(K_BYTE, 8'd0, 8'd0, ERR_NONE);

    always_comb begin
        f = feed(st_reg, cnt_reg, feed_byte, sep_reg, quo_reg, exp_reg, known_reg);
    end

    always_comb begin
        st_next          = st_reg;
        cnt_next         = cnt_reg;
        exp_next         = exp_reg;
        known_next       = known_reg;
        prev_lf_next     = prev_lf_reg;
        err_latched_next = err_latched_reg;
        err_code_next    = err_code_reg;
        push             = 1'b0;
        push_entry.two   = 1'b0;
        push_entry.first = none_res;
        push_entry.second = none_res;
        fed              = !prev_lf_reg;
        after_err        = fed && f.err;
        after_st         = fed ? f.st : st_reg;
        final_res        = (after_st != ST_START)
                         ? make_result(K_ERR, 8'd0, 8'd0, ERR_EARLY_END)
                         : make_result(K_SEND, 8'd0, 8'd0, ERR_NONE);
        if (accept) begin
            case (s_cmd)
                CMD_RESTART: begin
                    st_next          = ST_START;
                    cnt_next         = 8'd0;
                    prev_lf_next     = 1'b1;
                    err_latched_next = 1'b0;
                    err_code_next    = ERR_NONE;
                end
                CMD_DATA, CMD_END: begin
                    if (err_latched_reg) begin
                        push             = 1'b1;
                        push_entry.first = make_result(K_ERR, 8'd0, 8'd0, err_code_reg);
                    end else if (s_cmd == CMD_DATA) begin
                        st_next          = f.st;
                        cnt_next         = f.cnt;
                        exp_next         = f.exp_cnt;
                        known_next       = f.known;
                        prev_lf_next     = (s_data_byte == LF_BYTE);
                        push             = f.emit;
                        push_entry.first = f.res;
                        if (f.err) begin
                            err_latched_next = 1'b1;
                            err_code_next    = f.res.error_code;
                        end
                    end else begin
                        push         = 1'b1;
                        prev_lf_next = 1'b1;
                        if (fed) begin
                            st_next    = f.st;
                            cnt_next   = f.cnt;
                            exp_next   = f.exp_cnt;
                            known_next = f.known;
                        end
                        if (after_err) begin
                            err_latched_next = 1'b1;
                            err_code_next    = f.res.error_code;
                        end else if (after_st != ST_START) begin
                            err_latched_next = 1'b1;
                            err_code_next    = ERR_EARLY_END;
                        end
                        if (fed && f.emit) begin
                            push_entry.first = f.res;
                            if (!after_err) begin
                                push_entry.two    = 1'b1;
                                push_entry.second = final_res;
                            end
                        end else begin
                            push_entry.first = final_res;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= ST_START;
            cnt_reg         <= 8'd0;
            exp_reg         <= 8'd0;
            known_reg       <= 1'b0;
            prev_lf_reg     <= 1'b1;
            err_latched_reg <= 1'b0;
            err_code_reg    <= ERR_NONE;
            sep_reg         <= SEPARATOR_RESET;
            quo_reg         <= QUOTE_RESET;
        end else begin
            st_reg          <= st_next;
            cnt_reg         <= cnt_next;
            exp_reg         <= exp_next;
            known_reg       <= known_next;
            prev_lf_reg     <= prev_lf_next;
            err_latched_reg <= err_latched_next;
            err_code_reg    <= err_code_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEPARATOR: sep_reg <= cfg_data;
                    CFG_QUOTE:     quo_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/csvt_queue.sv =====
`default_nettype none

module csvt_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire csvt_pkg::queue_entry_t push_entry,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        head_valid,
    output csvt_pkg::queue_entry_t      head_entry
);
    import csvt_pkg::*;

    queue_entry_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/csvt_back.sv =====
`default_nettype none

`include "csv_record_tokenizer_assert.svh"

module csvt_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    head_valid,
    input  wire csvt_pkg::queue_entry_t  head_entry,
    output logic                         pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [2:0]                   m_kind,
    output logic [7:0]                   m_content_byte,
    output logic [7:0]                   m_fields_in_record,
    output logic [2:0]                   m_error_code,
    output logic                         m_last
);
    import csvt_pkg::*;

    logic    out_valid_reg;
    logic    out_last_reg;
    result_t out_res_reg;
    logic    pend_valid_reg;
    result_t pend_res_reg;
    logic    advance;

    assign advance = !out_valid_reg || m_ready;
    assign pop     = advance && !pend_valid_reg && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (advance) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (head_valid) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= head_entry.two;
            end else begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // second result of a pair waits in the pending slot
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pend_valid_reg) begin
                out_res_reg  <= pend_res_reg;
                out_last_reg <= 1'b1;
            end else if (head_valid) begin
                out_res_reg  <= head_entry.first;
                out_last_reg <= !head_entry.two;
                pend_res_reg <= head_entry.second;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_kind             = out_res_reg.kind;
    assign m_content_byte     = out_res_reg.content_byte;
    assign m_fields_in_record = out_res_reg.fields_in_record;
    assign m_error_code       = out_res_reg.error_code;
    assign m_last             = out_last_reg;

    `CSVT_ASSERT_IMPL(a_pend_needs_out, pend_valid_reg, out_valid_reg, "pending result with no output")
    `CSVT_ASSERT_IMPL(a_pend_not_last, pend_valid_reg, !out_last_reg, "first of pair marked last")
    `CSVT_ASSERT_NEXT(a_pair_follows, out_valid_reg && !out_last_reg && m_ready, out_valid_reg && out_last_reg, "second result of pair missing")

endmodule

`default_nettype wire

// ===== src/csv_record_tokenizer.sv =====
`default_nettype none

// CSV tokenizer: takes one command (data byte, end of stream or restart) per transfer
// and produces content bytes, field ends, record ends, stream ends and sticky errors.
// One input transfer is taken every cycle while the two-entry queue between the
// parser and the output stage has room; each result is one output transfer, so an
// item with one result sustains one byte per cycle while m_ready is held high, and
// an end of stream that closes an unterminated last line gives two results.
// Each result passes through the queue entry and then the output register before
// m_valid rises. Restart and unused commands produce no result. The user must
// write the separator and quote registers through the cfg port (index 0 separator,
// index 1 quote) only while idle; the block itself does not enforce this.
module csv_record_tokenizer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_cmd,
    input  wire logic [7:0]                        s_data_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [2:0]                             m_kind,
    output logic [7:0]                             m_content_byte,
    output logic [7:0]                             m_fields_in_record,
    output logic [2:0]                             m_error_code,
    output logic                                   m_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                        cfg_data
);
    import csvt_pkg::*;

    logic         q_full;
    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    logic         head_valid;
    queue_entry_t head_entry;

    csvt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    csvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    csvt_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head_entry         (head_entry),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_content_byte     (m_content_byte),
        .m_fields_in_record (m_fields_in_record),
        .m_error_code       (m_error_code),
        .m_last             (m_last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/csv_record_tokenizer_tb.sv =====
import csvt_pkg::*;

class csv_token_tracker;
    typedef struct {
        kind_t      kind;
        logic [7:0] content;
        logic [7:0] count;
        error_t     code;
        logic       last;
    } token_t;

    logic [7:0] sep;
    logic [7:0] quo;
    state_t     pstate;
    int         nfields;
    int         expect_n;
    bit         expect_known;
    bit         prev_lf;
    bit         err_on;
    error_t     err_code;
    token_t     pending[$];
    token_t     step_out[$];
    int         errors;

    function new();
        sep = SEPARATOR_RESET;
        quo = QUOTE_RESET;
        expect_n = 0;
        expect_known = 0;
        errors = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        pstate = ST_START;
        nfields = 0;
        prev_lf = 1'b1;
        err_on = 1'b0;
        err_code = ERR_NONE;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        if (idx == CFG_SEPARATOR) begin
            sep = val;
        end else if (idx == CFG_QUOTE) begin
            quo = val;
        end
    endfunction

    function void put(kind_t k, logic [7:0] c, int n, error_t e);
        token_t t;
        if (step_out.size() >= 2) return;
        t.kind = k;
        t.content = c;
        t.count = n[7:0];
        t.code = e;
        t.last = 1'b0;
        step_out.insert(step_out.size(), t);
    endfunction

    function void latch_error(error_t e);
        err_on = 1'b1;
        err_code = e;
        put(K_ERR, 8'd0, 0, e);
    endfunction

    function bit bump_count();
        if (nfields >= FIELD_LIMIT) begin
            latch_error(ERR_TOO_MANY);
            return 1'b0;
        end
        nfields++;
        return 1'b1;
    endfunction

    function void close_one();
        if (bump_count()) begin
            put(K_FEND, 8'd0, nfields, ERR_NONE);
            pstate = ST_START;
        end
    endfunction

    function void finish_record(bit closing);
        if (closing && !bump_count()) return;
        if (expect_known && nfields != expect_n) begin
            latch_error(ERR_COUNT);
            return;
        end
        put(closing ? K_RECF : K_RECE, 8'd0, nfields, ERR_NONE);
        if (!expect_known) begin
            expect_n = nfields;
            expect_known = 1'b1;
        end
        nfields = 0;
        pstate = ST_START;
    endfunction

    function void parse_byte(logic [7:0] c);
        case (pstate)
            ST_UNQ: begin
                if (c == LF_BYTE) finish_record(1'b1);
                else if (c == CR_BYTE) pstate = ST_CRF;
                else if (c == sep) close_one();
                else if (c == quo) latch_error(ERR_QUOTE);
                else put(K_BYTE, c, 0, ERR_NONE);
            end
            ST_QUO: begin
                if (c == quo) pstate = ST_AFTQ;
                else put(K_BYTE, c, 0, ERR_NONE);
            end
            ST_AFTQ: begin
                if (c == LF_BYTE) finish_record(1'b1);
                else if (c == CR_BYTE) pstate = ST_CRF;
                else if (c == sep) close_one();
                else if (c == quo) begin
                    put(K_BYTE, c, 0, ERR_NONE);
                    pstate = ST_QUO;
                end else latch_error(ERR_AFTER_QUOTE);
            end
            ST_CRF: begin
                if (c == LF_BYTE) finish_record(1'b1);
                else latch_error(ERR_AFTER_CR);
            end
            ST_CRE: begin
                if (c == LF_BYTE) finish_record(1'b0);
                else latch_error(ERR_AFTER_CR);
            end
            default: begin
                pstate = ST_START;
                if (c == LF_BYTE) finish_record(1'b0);
                else if (c == CR_BYTE) pstate = ST_CRE;
                else if (c == sep) close_one();
                else if (c == quo) pstate = ST_QUO;
                else begin
                    put(K_BYTE, c, 0, ERR_NONE);
                    pstate = ST_UNQ;
                end
            end
        endcase
    endfunction

    // one accepted input transfer
    function void note_input(logic [1:0] cmd, logic [7:0] c);
        step_out.delete();
        if (cmd == CMD_RESTART) begin
            clear_parse();
        end else if (cmd == CMD_DATA || cmd == CMD_END) begin
            if (err_on) begin
                put(K_ERR, 8'd0, 0, err_code);
            end else if (cmd == CMD_DATA) begin
                parse_byte(c);
                prev_lf = (c == LF_BYTE);
            end else begin
                if (!prev_lf) begin
                    parse_byte(LF_BYTE);
                    prev_lf = 1'b1;
                end
                if (!err_on) begin
                    if (pstate != ST_START) latch_error(ERR_EARLY_END);
                    else put(K_SEND, 8'd0, 0, ERR_NONE);
                end
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) pending.insert(pending.size(), step_out[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // one accepted result transfer
    function void check_result(logic [2:0] kind, logic [7:0] content, logic [7:0] count,
                               logic [2:0] code, logic last);
        token_t e;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got kind %0d", $time, kind);
            return;
        end
        e = pending.pop_front();
        compare_field("kind", 8'(e.kind), 8'(kind));
        compare_field("content_byte", e.content, content);
        compare_field("fields_in_record", e.count, count);
        compare_field("error_code", 8'(e.code), 8'(code));
        compare_field("last", 8'(e.last), 8'(last));
    endfunction
endclass

module csv_record_tokenizer_tb;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);
    localparam int CYCLE_LIMIT = 300000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_cmd = CMD_DATA;
    logic [7:0] s_data_byte = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_content_byte;
    logic [7:0] m_fields_in_record;
    logic [2:0] m_error_code;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SEPARATOR;
    logic [7:0] cfg_data = 8'd0;

    int src_idle = 0;
    int dst_idle = 0;
    int items_sent = 0;
    int cycles = 0;
    csv_token_tracker trk = new();

    logic [7:0] sep_tab [9] = '{8'd44, 8'h00, 8'hff, 8'd9, 8'd44, LF_BYTE, CR_BYTE, 8'd59, 8'd0};
    logic [7:0] quo_tab [9] = '{8'd34, 8'hff, 8'h00, 8'd39, 8'd34, CR_BYTE, LF_BYTE, 8'd59, 8'd0};

    csv_record_tokenizer uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_content_byte(m_content_byte),
        .m_fields_in_record(m_fields_in_record),
        .m_error_code(m_error_code),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) trk.set_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                trk.check_result(m_kind, m_content_byte, m_fields_in_record,
                                 m_error_code, m_last);
            end
            if (s_valid && s_ready) trk.note_input(s_cmd, s_data_byte);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("csv_record_tokenizer_tb: errors");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic put_data(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if ($urandom_range(199) == 0) push_cmd(CMD_END, 8'($urandom));
        else if ($urandom_range(199) == 0) push_cmd(CMD_UNUSED, 8'($urandom));
        if ($urandom_range(99) < 2) v = 8'($urandom);
        push_cmd(CMD_DATA, v);
    endtask

    task automatic settle(input int extra);
        s_valid <= 1'b0;
        while (trk.pending.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] sep, input logic [7:0] quo, input bit spare);
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE, quo);
        if (spare) begin
            write_reg(CFG_SPARE_A, 8'($urandom));
            write_reg(CFG_SPARE_B, 8'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == LF_BYTE || c == CR_BYTE || c == trk.sep || c == trk.quo);
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do begin
            case ($urandom_range(5))
                0: c = trk.sep;
                1: c = CR_BYTE;
                2: c = LF_BYTE;
                default: c = 8'($urandom);
            endcase
        end while (c == trk.quo);
        return c;
    endfunction

    task automatic put_record();
        int nf;
        int n;
        nf = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : trk.expect_n;
        for (int f = 0; f < nf; f++) begin
            if (f > 0) put_data(trk.sep);
            if ($urandom_range(2) == 0) begin
                put_data(trk.quo);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(4) == 0) begin
                        put_data(trk.quo);
                        put_data(trk.quo);
                    end else begin
                        put_data(quoted_char());
                    end
                end
                put_data(trk.quo);
            end else begin
                n = $urandom_range((f == nf - 1 && $urandom_range(7) != 0) ? 1 : 0, 4);
                repeat (n) put_data(plain_char());
            end
        end
        if ($urandom_range(2) == 0) put_data(CR_BYTE);
        put_data(LF_BYTE);
    endtask

    // a run of separators, one plain byte and lf, then restart; long enough to reach the field limit
    task automatic wide_record(input int n);
        repeat (n) push_cmd(CMD_DATA, trk.sep);
        push_cmd(CMD_DATA, plain_char());
        push_cmd(CMD_DATA, LF_BYTE);
        push_cmd(CMD_RESTART, 8'($urandom));
    endtask

    initial begin
        int goal;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // quoted separator, doubled quote, quoted lf, crlf; fixes three fields
        push_cmd(CMD_DATA, "a");
        push_cmd(CMD_DATA, ",");
        push_cmd(CMD_DATA, "\"");
        push_cmd(CMD_DATA, ",");
        push_cmd(CMD_DATA, "\"");
        push_cmd(CMD_DATA, "\"");
        push_cmd(CMD_DATA, LF_BYTE);
        push_cmd(CMD_DATA, "\"");
        push_cmd(CMD_DATA, ",");
        push_cmd(CMD_DATA, 8'hff);
        push_cmd(CMD_DATA, CR_BYTE);
        push_cmd(CMD_DATA, LF_BYTE);
        // empty line gives count mismatch, then sticky error
        push_cmd(CMD_DATA, LF_BYTE);
        push_cmd(CMD_DATA, 8'h00);
        push_cmd(CMD_END, 8'h00);
        push_cmd(CMD_RESTART, 8'hff);
        push_cmd(CMD_UNUSED, 8'h55);
        // end of stream without final lf
        push_cmd(CMD_DATA, 8'h00);
        push_cmd(CMD_DATA, ",");
        push_cmd(CMD_DATA, ",");
        push_cmd(CMD_DATA, "z");
        push_cmd(CMD_END, 8'hff);
        push_cmd(CMD_END, 8'h00);
        // stream ends inside a quoted field
        push_cmd(CMD_DATA, "\"");
        push_cmd(CMD_END, 8'h00);

        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin src_idle = 8; dst_idle = 58; end
                1: begin src_idle = 58; dst_idle = 8; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            settle(8);
            if (p == 8) program_regs(8'($urandom), 8'($urandom), 1'b1);
            else program_regs(sep_tab[p], quo_tab[p], 1'b0);
            push_cmd(CMD_RESTART, 8'($urandom));
            if (p == 0) wide_record(255);
            if (p == 4) wide_record($urandom_range(254, 256));
            goal = items_sent + ((p == 5 || p == 6) ? 80 : 190);
            while (items_sent < goal) begin
                put_record();
                if ($urandom_range(19) == 0) push_cmd(CMD_END, 8'($urandom));
                if ($urandom_range(24) == 0) put_data(LF_BYTE);
                if (trk.err_on) begin
                    repeat ($urandom_range(0, 2)) begin
                        push_cmd($urandom_range(1) ? CMD_END : CMD_DATA, 8'($urandom));
                    end
                    push_cmd(CMD_RESTART, 8'($urandom));
                end else if ($urandom_range(39) == 0) begin
                    push_cmd(CMD_RESTART, 8'($urandom));
                end
            end
        end

        settle(12);
        if (trk.errors == 0 && trk.pending.size() == 0) begin
            $display("csv_record_tokenizer_tb: clean");
        end else begin
            $display("csv_record_tokenizer_tb: errors");
        end
        $finish;
    end
endmodule
